/* rtl/core/vhw_pkg.sv */
// Shared types, constants and helper functions for the VHW water speed sentence parser.
package vhw_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_FIELDS_DEF  = 15;
  localparam int MIN_FIELDS_DEF  = 7;
  localparam int SPEED_WIDTH_DEF = 24;

  // Fixed widths and sizes.
  localparam int FIELD_W     = 4;
  localparam int PREFIX_LEN  = 6;
  localparam int POS_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  // Field numbers with a meaning of their own.
  localparam logic [FIELD_W-1:0] FLD_KNOTS      = 4'd5;
  localparam logic [FIELD_W-1:0] FLD_KNOTS_UNIT = 4'd6;
  localparam logic [FIELD_W-1:0] FLD_KMH        = 4'd7;
  localparam logic [FIELD_W-1:0] FLD_KMH_UNIT   = 4'd8;

  // Character codes.
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Byte classes produced by the front end.
  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_DOT,
    CLS_PLUS,
    CLS_MINUS,
    CLS_SPACE,
    CLS_COMMA,
    CLS_STAR,
    CLS_OTHER
  } char_class_t;

  // Number parsing phase, one-hot.
  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_INT   = 4'b0010,
    PH_FRAC  = 4'b0100,
    PH_STOP  = 4'b1000
  } num_phase_t;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0]  ch;
    char_class_t cls;
    logic        eos;
    logic        prefix_ok;
  } byte_item_t;

  // Expected sentence prefix "$VWVHW".
  function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h56;
      3'd2:    c = 8'h57;
      3'd3:    c = 8'h56;
      3'd4:    c = 8'h48;
      3'd5:    c = 8'h57;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/nmea_vhw_water_speed_parser_unit.sv */
// Top level of the VHW water speed sentence parser.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------------------------
//  in       | in_valid/in_ready  | in_char_in, in_end_of_sentence
//  out      | out_valid/out_ready| out_sentence_ok, out_speed_knots, out_knots_unit,
//           |                    | out_speed_kmh, out_kmh_unit
//
// One byte per cycle while the queue has room: each digit needs one scale and saturating add.
// A result is valid in the cycle after the back end takes the final byte of a sentence from the queue.
// A two-entry queue separates the classifying front end from the parsing back end.
// A held result stops a final byte at the queue head; one more byte is taken,
// then the input stalls until the result is taken.
// Reset is synchronous and active low.
module nmea_vhw_water_speed_parser_unit import vhw_pkg::*; #(
  parameter int MAX_FIELDS  = MAX_FIELDS_DEF,
  parameter int MIN_FIELDS  = MIN_FIELDS_DEF,
  parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_char_in,
  input  logic                          in_end_of_sentence,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_sentence_ok,
  output logic signed [SPEED_WIDTH-1:0] out_speed_knots,
  output logic [7:0]                    out_knots_unit,
  output logic signed [SPEED_WIDTH-1:0] out_speed_kmh,
  output logic [7:0]                    out_kmh_unit
);

  logic       q_full;
  logic       push;
  byte_item_t push_item;
  logic       pop;
  logic       head_valid;
  byte_item_t head_item;

  // Byte classification and prefix check.
  vhw_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_in         (in_char_in),
    .in_end_of_sentence (in_end_of_sentence),
    .q_full             (q_full),
    .push               (push),
    .push_item          (push_item)
  );

  // Decoupling queue.
  vhw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Field parsing and result register.
  vhw_back #(
    .MAX_FIELDS  (MAX_FIELDS),
    .MIN_FIELDS  (MIN_FIELDS),
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sentence_ok (out_sentence_ok),
    .out_speed_knots (out_speed_knots),
    .out_knots_unit  (out_knots_unit),
    .out_speed_kmh   (out_speed_kmh),
    .out_kmh_unit    (out_kmh_unit)
  );

endmodule

/* rtl/core/vhw_front.sv */
// Front end: accepts bytes, classifies them and tracks the sentence prefix.
module vhw_front import vhw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_sentence,
  input  logic       q_full,
  output logic       push,
  output byte_item_t push_item
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             fail_r, fail_nxt;
  char_class_t      cls;

  // A transfer happens whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Classify the incoming byte.
  always_comb begin
    if (in_char_in >= CH_ZERO && in_char_in <= CH_NINE) begin
      cls = CLS_DIGIT;
    end else if (in_char_in == CH_DOT) begin
      cls = CLS_DOT;
    end else if (in_char_in == CH_PLUS) begin
      cls = CLS_PLUS;
    end else if (in_char_in == CH_MINUS) begin
      cls = CLS_MINUS;
    end else if (in_char_in == CH_SPACE || (in_char_in >= CH_TAB && in_char_in <= CH_CR)) begin
      cls = CLS_SPACE;
    end else if (in_char_in == CH_COMMA) begin
      cls = CLS_COMMA;
    end else if (in_char_in == CH_STAR) begin
      cls = CLS_STAR;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // Compare the first six bytes of each sentence with the expected prefix.
  always_comb begin
    pos_nxt  = pos_r;
    fail_nxt = fail_r;
    if (pos_r < POS_W'(PREFIX_LEN)) begin
      if (in_char_in != prefix_char(pos_r)) begin
        fail_nxt = 1'b1;
      end
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // Queue entry for the back end.
  always_comb begin
    push_item.ch        = in_char_in;
    push_item.cls       = cls;
    push_item.eos       = in_end_of_sentence;
    push_item.prefix_ok = !fail_nxt && (pos_nxt == POS_W'(PREFIX_LEN));
  end

  // Prefix tracking restarts after the last byte of a sentence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fail_r <= 1'b0;
    end else if (push) begin
      if (in_end_of_sentence) begin
        pos_r  <= '0;
        fail_r <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        fail_r <= fail_nxt;
      end
    end
  end

endmodule

/* rtl/core/vhw_queue.sv */
// Short queue of classified bytes between the front end and the back end.
module vhw_queue import vhw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  byte_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output byte_item_t head_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  byte_item_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/vhw_back.sv */
// Back end: field splitting, number parsing and the result register.
module vhw_back import vhw_pkg::*; #(
  parameter int MAX_FIELDS  = MAX_FIELDS_DEF,
  parameter int MIN_FIELDS  = MIN_FIELDS_DEF,
  parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  byte_item_t                    head_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_sentence_ok,
  output logic signed [SPEED_WIDTH-1:0] out_speed_knots,
  output logic [7:0]                    out_knots_unit,
  output logic signed [SPEED_WIDTH-1:0] out_speed_kmh,
  output logic [7:0]                    out_kmh_unit
);

  localparam int SW    = SPEED_WIDTH;
  localparam int SUM_W = SPEED_WIDTH + 4;
  localparam logic [SW-1:0]      MAG_LIMIT  = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0]      MAX_POS    = {1'b0, {(SW-1){1'b1}}};
  localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(MAX_FIELDS - 1);

  // Parse state.
  logic               after_ast_r, after_ast_nxt;
  logic [FIELD_W-1:0] field_r, field_nxt;
  logic [SW-1:0]      knots_r, knots_nxt;
  logic [SW-1:0]      kmh_r, kmh_nxt;
  num_phase_t         phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [1:0]         frac_r, frac_nxt;
  logic [7:0]         kunit_r, kunit_nxt;
  logic [7:0]         munit_r, munit_nxt;

  // Result register.
  logic               out_valid_r;
  logic               out_ok_r;
  logic [SW-1:0]      out_knots_r, out_kmh_r;
  logic [7:0]         out_kunit_r, out_munit_r;
  logic               out_kconv_r, out_mconv_r, out_neg_r;

  logic               early;
  logic               num_field;
  logic [SW-1:0]      acc;
  logic [3:0]         digit;
  logic [SUM_W-1:0]   scaled, addend, sum;
  logic [SW-1:0]      acc_sat;
  logic               digit_takes;
  logic               take_eos;
  logic               sent_ok;

  // Magnitude to two's complement, positive values clamped.
  function automatic logic [SW-1:0] to_signed_word(input logic [SW-1:0] mag, input logic neg);
    logic [SW-1:0] w;
    if (neg) begin
      w = '0 - mag;
    end else begin
      w = (mag > MAX_POS) ? MAX_POS : mag;
    end
    return w;
  endfunction

  // A final byte waits for the result register to be free.
  assign pop      = head_valid && (!head_item.eos || !out_valid_r || out_ready);
  assign take_eos = pop && head_item.eos;

  // Shared multiply-by-ten and saturating add for both speed fields.
  assign early       = (phase_r == PH_START) || (phase_r == PH_INT);
  assign num_field   = (field_r == FLD_KNOTS) || (field_r == FLD_KMH);
  assign acc         = (field_r == FLD_KNOTS) ? knots_r : kmh_r;
  assign digit       = head_item.ch[3:0];
  assign scaled      = early ? (SUM_W'(acc) * SUM_W'(10)) : SUM_W'(acc);
  assign addend      = early ? (SUM_W'(digit) * SUM_W'(100)) :
                       (frac_r == 2'd0) ? (SUM_W'(digit) * SUM_W'(10)) : SUM_W'(digit);
  assign sum         = scaled + addend;
  assign acc_sat     = (sum > SUM_W'(MAG_LIMIT)) ? MAG_LIMIT : sum[SW-1:0];
  assign digit_takes = early || (phase_r == PH_FRAC && frac_r != 2'd2);

  // Next parse state for the byte at the head of the queue.
  always_comb begin
    after_ast_nxt = after_ast_r;
    field_nxt     = field_r;
    knots_nxt     = knots_r;
    kmh_nxt       = kmh_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    frac_nxt      = frac_r;
    kunit_nxt     = kunit_r;
    munit_nxt     = munit_r;
    if (pop && !after_ast_r) begin
      if (head_item.cls == CLS_STAR ||
          (head_item.cls == CLS_COMMA && field_r != LAST_FIELD)) begin
        // Close the open field.
        if (field_r == FLD_KNOTS) begin
          knots_nxt = to_signed_word(knots_r, neg_r);
        end else if (field_r == FLD_KMH) begin
          kmh_nxt = to_signed_word(kmh_r, neg_r);
        end
        if (head_item.cls == CLS_STAR) begin
          after_ast_nxt = 1'b1;
        end else begin
          field_nxt = field_r + FIELD_W'(1);
          phase_nxt = PH_START;
          neg_nxt   = 1'b0;
          frac_nxt  = 2'd0;
        end
      end else if (num_field) begin
        // Number syntax inside a speed field.
        if (phase_r != PH_STOP) begin
          case (head_item.cls) inside
            CLS_DIGIT: begin
              if (digit_takes) begin
                if (field_r == FLD_KNOTS) begin
                  knots_nxt = acc_sat;
                end else begin
                  kmh_nxt = acc_sat;
                end
                if (early) begin
                  phase_nxt = PH_INT;
                end else begin
                  frac_nxt = frac_r + 2'd1;
                end
              end
            end
            CLS_DOT: begin
              phase_nxt = early ? PH_FRAC : PH_STOP;
            end
            CLS_PLUS, CLS_MINUS: begin
              if (phase_r == PH_START) begin
                neg_nxt   = (head_item.cls == CLS_MINUS);
                phase_nxt = PH_INT;
              end else begin
                phase_nxt = PH_STOP;
              end
            end
            CLS_SPACE: begin
              if (phase_r != PH_START) begin
                phase_nxt = PH_STOP;
              end
            end
            default: begin
              phase_nxt = PH_STOP;
            end
          endcase
        end
      end else if (field_r == FLD_KNOTS_UNIT || field_r == FLD_KMH_UNIT) begin
        // Unit fields keep their first byte.
        if (phase_r == PH_START) begin
          if (field_r == FLD_KNOTS_UNIT) begin
            kunit_nxt = head_item.ch;
          end else begin
            munit_nxt = head_item.ch;
          end
          phase_nxt = PH_STOP;
        end
      end
    end
  end

  assign sent_ok = head_item.prefix_ok &&
                   ((5'(field_nxt) + 5'd1) >= 5'(MIN_FIELDS));

  // Parse state registers; everything restarts after a final byte.
  always_ff @(posedge clk) begin
    if (!rst_n || take_eos) begin
      after_ast_r <= 1'b0;
      field_r     <= '0;
      knots_r     <= '0;
      kmh_r       <= '0;
      phase_r     <= PH_START;
      neg_r       <= 1'b0;
      frac_r      <= 2'd0;
      kunit_r     <= CH_SPACE;
      munit_r     <= CH_SPACE;
    end else begin
      after_ast_r <= after_ast_nxt;
      field_r     <= field_nxt;
      knots_r     <= knots_nxt;
      kmh_r       <= kmh_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      frac_r      <= frac_nxt;
      kunit_r     <= kunit_nxt;
      munit_r     <= munit_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_eos) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; a still open speed field is converted on the way out.
  always_ff @(posedge clk) begin
    if (take_eos) begin
      out_ok_r    <= sent_ok;
      out_knots_r <= sent_ok ? knots_nxt : '0;
      out_kmh_r   <= sent_ok ? kmh_nxt : '0;
      out_kunit_r <= sent_ok ? kunit_nxt : CH_SPACE;
      out_munit_r <= sent_ok ? munit_nxt : CH_SPACE;
      out_kconv_r <= sent_ok && !after_ast_nxt && (field_nxt == FLD_KNOTS);
      out_mconv_r <= sent_ok && !after_ast_nxt && (field_nxt == FLD_KMH);
      out_neg_r   <= neg_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sentence_ok = out_ok_r;
  assign out_speed_knots = out_kconv_r ? to_signed_word(out_knots_r, out_neg_r) : out_knots_r;
  assign out_speed_kmh   = out_mconv_r ? to_signed_word(out_kmh_r, out_neg_r) : out_kmh_r;
  assign out_knots_unit  = out_kunit_r;
  assign out_kmh_unit    = out_munit_r;

  // The field counter never passes the last field.
  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    field_r <= LAST_FIELD)
    else $error("field counter beyond last field");

  // A final byte is never taken while an untaken result is held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(take_eos && out_valid_r && !out_ready))
    else $error("result overwritten");

  // After a final byte the parse state is back at its start.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take_eos |=> (field_r == '0 && !after_ast_r && phase_r == PH_START && out_valid_r))
    else $error("parse state not restarted after final byte");

  // A rejected sentence carries zero speeds.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_knots_r == '0 && out_kmh_r == '0))
    else $error("rejected sentence with nonzero speed");

endmodule
